### rtl/nwdc_pkg.sv
// ----------------------------------------------------------------------------
// nwdc_pkg
// Shared types and constants for the network wake-up duty controller.
// ----------------------------------------------------------------------------
package nwdc_pkg;

    localparam int unsigned CntW     = 16;
    localparam int unsigned CfgW     = 16;
    localparam int unsigned CfgIdxW  = 1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_WAKEUP_TICKS = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_ALIVE_TICKS  = 1'd1;

    // register reset values
    localparam logic [CfgW-1:0] WAKEUP_TICKS_RST = 16'd20;
    localparam logic [CfgW-1:0] ALIVE_TICKS_RST  = 16'd600;

    typedef enum logic [1:0] {
        MODE_LISTEN   = 2'd0,
        MODE_WAKING   = 2'd1,
        MODE_ALIVE    = 2'd2,
        MODE_SHUTDOWN = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_WAKEUP   = 3'd1,
        OP_SHUTDOWN = 3'd2,
        OP_ACTIVITY = 3'd3,
        OP_SENDDONE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        BC_NONE     = 2'd0,
        BC_WAKEUP   = 2'd1,
        BC_SHUTDOWN = 2'd2
    } t_bc;

    // input word
    typedef struct packed {
        logic [2:0] operation;
        logic       send_was_own;
        logic       send_accepted;
    } t_in_word;

    // result word
    typedef struct packed {
        logic       sleep_request;
        logic [1:0] broadcast;
        logic [1:0] mode;
        logic       pending;
    } t_out_word;

    // handshake between pipeline stages
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

### rtl/nwdc_in_stage.sv
// ----------------------------------------------------------------------------
// nwdc_in_stage
// Input register: captures one word and holds it until the step logic
// hands its result to the output stage.
// ----------------------------------------------------------------------------
module nwdc_in_stage
    import nwdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output t_hs      o_hs,
    input  logic     i_take,
    output t_in_word o_data
);

    logic     r_valid;
    logic     n_valid;
    t_in_word r_data;

    // free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_hs.valid = r_valid;
    assign o_hs.ready = o_ready;
    assign o_data     = r_data;

endmodule

### rtl/nwdc_step.sv
// ----------------------------------------------------------------------------
// nwdc_step
// Mode, counter and pending state with the update logic for one word,
// plus the two configuration registers.
// ----------------------------------------------------------------------------
module nwdc_step
    import nwdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_advance,
    input  t_in_word           i_data,
    output t_out_word          o_result
);

    logic [CfgW-1:0] r_wakeup_ticks;
    logic [CfgW-1:0] r_alive_ticks;
    t_mode           r_mode;
    t_mode           n_mode;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_pending;
    logic            n_pending;
    logic            sleep;
    t_bc             bc;
    logic [CntW-1:0] cnt_inc;
    logic [CntW-1:0] cnt_dec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wakeup_ticks <= WAKEUP_TICKS_RST;
            r_alive_ticks  <= ALIVE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAKEUP_TICKS: r_wakeup_ticks <= i_cfg_data;
                CFG_ALIVE_TICKS:  r_alive_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cnt_inc = r_count + 1'b1;
    assign cnt_dec = r_count - 1'b1;

    // next state and result for the held word
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_pending = r_pending;
        sleep     = 1'b0;
        bc        = BC_NONE;
        case (t_op'(i_data.operation))
            OP_TICK: begin
                case (r_mode)
                    MODE_LISTEN, MODE_SHUTDOWN: sleep = 1'b1;
                    MODE_WAKING: begin
                        n_count = cnt_inc;
                        if (cnt_inc == r_wakeup_ticks) begin
                            n_mode  = MODE_ALIVE;
                            n_count = r_alive_ticks;
                        end
                    end
                    default: begin
                        n_count = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_mode = MODE_LISTEN;
                        end
                    end
                endcase
            end
            OP_WAKEUP: begin
                if (r_mode == MODE_LISTEN) begin
                    n_mode  = MODE_WAKING;
                    n_count = '0;
                end
                if (r_mode == MODE_LISTEN || r_mode == MODE_WAKING) begin
                    bc = BC_WAKEUP;
                    if (i_data.send_accepted) begin
                        n_pending = 1'b1;
                    end
                end
            end
            OP_SHUTDOWN: begin
                n_mode = MODE_SHUTDOWN;
                bc     = BC_SHUTDOWN;
                if (i_data.send_accepted) begin
                    n_pending = 1'b1;
                end
            end
            OP_ACTIVITY: begin
                if (r_mode == MODE_LISTEN || r_mode == MODE_ALIVE) begin
                    n_mode  = MODE_ALIVE;
                    n_count = r_alive_ticks;
                end
            end
            OP_SENDDONE: begin
                if (i_data.send_was_own) begin
                    n_pending = 1'b0;
                    if (r_mode == MODE_WAKING) begin
                        bc = BC_WAKEUP;
                        if (i_data.send_accepted) begin
                            n_pending = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // state registers, updated as the word moves to the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ALIVE;
            r_count   <= '0;
            r_pending <= 1'b0;
        end else if (i_advance) begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_pending <= n_pending;
        end
    end

    assign o_result.sleep_request = sleep;
    assign o_result.broadcast     = bc;
    assign o_result.mode          = n_mode;
    assign o_result.pending       = n_pending;

    // a sleep request leaves mode and counter alone and sends nothing
    a_sleep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && sleep) |=> (r_mode == $past(r_mode) && $stable(r_count)))
        else $error("sleep request changed state");

    a_sleep_no_bc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sleep) |-> (bc == BC_NONE))
        else $error("sleep request with broadcast");

    // pending only rises on an accepted broadcast
    a_pending_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> $past(i_advance && bc != BC_NONE && i_data.send_accepted))
        else $error("pending set without accepted broadcast");

    // waking is only entered from listen
    a_waking_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_WAKING && $past(r_mode) != MODE_WAKING)
            |-> ($past(r_mode) == MODE_LISTEN))
        else $error("waking entered from wrong mode");

endmodule

### rtl/nwdc_out_stage.sv
// ----------------------------------------------------------------------------
// nwdc_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module nwdc_out_stage
    import nwdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_data,
    output t_hs       o_hs,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic      r_valid;
    logic      n_valid;
    t_out_word r_data;
    logic      room;

    // room for a new word when empty or draining this cycle
    assign room = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (room) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && room) begin
            r_data <= i_data;
        end
    end

    assign o_hs.valid = r_valid;
    assign o_hs.ready = room;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

endmodule

### rtl/network_wakeup_duty_controller_core.sv
// ----------------------------------------------------------------------------
// network_wakeup_duty_controller_core
// Radio wake-up controller: input register, combinational state update,
// result register.
// ----------------------------------------------------------------------------
// Flow: an accepted word is held in the input register, and its result is
//   loaded into the result register that drives o_out_valid.
// Throughput: one word per cycle while the result register has room.
// Reset (synchronous, i_rst_n low): mode alive, counter zero, pending clear,
//   wakeup_ticks 20, alive_ticks 600, both stages empty.
module network_wakeup_duty_controller_core
    import nwdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_data
);

    t_hs       in_hs;
    t_hs       out_hs;
    t_in_word  held;
    t_out_word result;
    logic      advance;

    // held word moves on when the result register has room
    assign advance = in_hs.valid && out_hs.ready;

    nwdc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_hs    (in_hs),
        .i_take  (advance),
        .o_data  (held)
    );

    nwdc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_data     (held),
        .o_result   (result)
    );

    nwdc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_data  (result),
        .o_hs    (out_hs),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // input side never blocks while the pipeline can move
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_hs.valid || advance) |-> in_hs.ready)
        else $error("input stalled with free stage");

    // a word left in the input stage is never dropped
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_hs.valid && !advance) |=> in_hs.valid)
        else $error("held word lost");

    // the result register fills only from an advancing word
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!out_hs.valid && !advance) |=> !out_hs.valid)
        else $error("result appeared without a word");

endmodule
